### hdl/srsi_pkg.sv
// shared types and constants of the sorted reference set intersection block
package srsi_pkg;

	localparam int ReqW      = 3;
	localparam int FileInW   = 8;
	localparam int StartW    = 32;
	localparam int LenW      = 16;
	localparam int IdxW      = 10;
	localparam int CountOutW = 11;
	localparam int TotalW    = 26;
	localparam int InTdataW  = 72;
	localparam int OutTdataW = 96;

	localparam logic [ReqW-1:0] REQ_LOAD  = 3'd0;
	localparam logic [ReqW-1:0] REQ_ISECT = 3'd1;
	localparam logic [ReqW-1:0] REQ_END   = 3'd2;
	localparam logic [ReqW-1:0] REQ_READ  = 3'd3;
	localparam logic [ReqW-1:0] REQ_CLEAR = 3'd4;

	// result item, last field in the lowest bits
	typedef struct packed {
		logic [LenW-1:0]      entry_length;
		logic [StartW-1:0]    entry_start;
		logic [FileInW-1:0]   entry_file;
		logic                 entry_valid;
		logic                 overflow;
		logic                 matched;
		logic [TotalW-1:0]    total_length;
		logic [CountOutW-1:0] set_count;
	} res_t;

endpackage

### hdl/srsi_mem.sv
// reference table memory, one write port and one registered read port
module srsi_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 56
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

### hdl/srsi_ctrl.sv
// sequencer for load, merge, commit and read-out against the reference table
module srsi_ctrl #(
	parameter int MAX_REFS     = 1024,
	parameter int FILE_ID_BITS = 8,
	localparam int AW = $clog2(MAX_REFS),
	localparam int KW = FILE_ID_BITS + 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [srsi_pkg::ReqW-1:0]      in_req,
	input  logic [srsi_pkg::FileInW-1:0]   in_file,
	input  logic [srsi_pkg::StartW-1:0]    in_start,
	input  logic [srsi_pkg::LenW-1:0]      in_len,
	input  logic [srsi_pkg::IdxW-1:0]      in_idx,
	output logic                           res_valid,
	input  logic                           res_ready,
	output srsi_pkg::res_t                 res,
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_waddr,
	output logic [KW-1:0]                  mem_wdata,
	output logic                           mem_re,
	output logic [AW-1:0]                  mem_raddr,
	input  logic [KW-1:0]                  mem_rdata
);

	import srsi_pkg::*;

	localparam int CW = $clog2(MAX_REFS + 1);
	localparam int XW = (CW > IdxW) ? CW : IdxW;
	localparam int FW = FILE_ID_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_RDW  = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     cmp_q, cmp_d;
	logic [CW-1:0]     copy_q, copy_d;
	logic [TotalW-1:0] total_q, total_d;
	logic [TotalW-1:0] pass_q, pass_d;
	logic              matched_q, matched_d;
	logic              ovf_q, ovf_d;
	logic              evalid_q, evalid_d;
	logic [ReqW-1:0]   req_q, req_d;
	logic [KW-1:0]     key_q, key_d;
	logic [IdxW-1:0]   idx_q, idx_d;
	logic [KW-1:0]     ekey_q, ekey_d;

	logic [FW+FileInW-1:0] file_in_ext;
	logic [FW+FileInW-1:0] file_out_ext;
	logic [XW-1:0]         idx_x;
	logic [XW-1:0]         count_x;
	logic [CW-1:0]         cmp_nx;
	logic                  fin;

	assign file_in_ext  = {FW'(0), in_file};
	assign file_out_ext = {FileInW'(0), ekey_d[KW-1:48]};
	assign idx_x        = XW'(idx_q);
	assign count_x      = XW'(count_q);
	assign cmp_nx       = cmp_q + CW'(1);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		cmp_d     = cmp_q;
		copy_d    = copy_q;
		total_d   = total_q;
		pass_d    = pass_q;
		matched_d = matched_q;
		ovf_d     = ovf_q;
		evalid_d  = evalid_q;
		req_d     = req_q;
		key_d     = key_q;
		idx_d     = idx_q;
		ekey_d    = ekey_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		fin       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d   = ST_EXEC;
					req_d     = in_req;
					key_d     = {file_in_ext[FW-1:0], in_start, in_len};
					idx_d     = in_idx;
					matched_d = 1'b0;
					ovf_d     = 1'b0;
					evalid_d  = 1'b0;
				end
			end
			ST_EXEC: begin
				case (req_q)
					REQ_LOAD: begin
						if (count_q < CW'(MAX_REFS)) begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
							mem_wdata = key_q;
							count_d   = count_q + CW'(1);
							total_d   = total_q + TotalW'(key_q[LenW-1:0]);
						end else begin
							ovf_d = 1'b1;
						end
						cmp_d  = '0;
						copy_d = '0;
						pass_d = '0;
						fin    = 1'b1;
					end
					REQ_ISECT: begin
						if (cmp_q < count_q) begin
							mem_re    = 1'b1;
							mem_raddr = cmp_q[AW-1:0];
							state_d   = ST_CMP;
						end else begin
							fin = 1'b1;
						end
					end
					REQ_END: begin
						count_d = copy_q;
						total_d = pass_q;
						cmp_d   = '0;
						copy_d  = '0;
						pass_d  = '0;
						fin     = 1'b1;
					end
					REQ_READ: begin
						if (idx_x < count_x) begin
							mem_re    = 1'b1;
							mem_raddr = idx_x[AW-1:0];
							state_d   = ST_RDW;
						end else begin
							fin = 1'b1;
						end
					end
					REQ_CLEAR: begin
						count_d = '0;
						total_d = '0;
						cmp_d   = '0;
						copy_d  = '0;
						pass_d  = '0;
						fin     = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_CMP: begin
				if (key_q < mem_rdata) begin
					fin = 1'b1;
				end else if (key_q == mem_rdata) begin
					mem_we    = 1'b1;
					mem_waddr = copy_q[AW-1:0];
					mem_wdata = mem_rdata;
					pass_d    = pass_q + TotalW'(mem_rdata[LenW-1:0]);
					copy_d    = copy_q + CW'(1);
					cmp_d     = cmp_nx;
					matched_d = 1'b1;
					fin       = 1'b1;
				end else begin
					cmp_d = cmp_nx;
					if (cmp_nx < count_q) begin
						mem_re    = 1'b1;
						mem_raddr = cmp_nx[AW-1:0];
					end else begin
						fin = 1'b1;
					end
				end
			end
			ST_RDW: begin
				evalid_d = 1'b1;
				ekey_d   = mem_rdata;
				fin      = 1'b1;
			end
			ST_HOLD: begin
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res_valid = fin || (state_q == ST_HOLD);
		if (res_valid) begin
			state_d = res_ready ? ST_IDLE : ST_HOLD;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		res.set_count    = CountOutW'(count_d);
		res.total_length = total_d;
		res.matched      = matched_d;
		res.overflow     = ovf_d;
		res.entry_valid  = evalid_d;
		res.entry_file   = evalid_d ? file_out_ext[FileInW-1:0] : '0;
		res.entry_start  = evalid_d ? ekey_d[47:16] : '0;
		res.entry_length = evalid_d ? ekey_d[LenW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			cmp_q     <= '0;
			copy_q    <= '0;
			total_q   <= '0;
			pass_q    <= '0;
			matched_q <= 1'b0;
			ovf_q     <= 1'b0;
			evalid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			cmp_q     <= cmp_d;
			copy_q    <= copy_d;
			total_q   <= total_d;
			pass_q    <= pass_d;
			matched_q <= matched_d;
			ovf_q     <= ovf_d;
			evalid_q  <= evalid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q  <= req_d;
		key_q  <= key_d;
		idx_q  <= idx_d;
		ekey_q <= ekey_d;
	end

endmodule

### hdl/srsi_out.sv
// output register between the sequencer and the result stream
module srsi_out (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             res_valid,
	output logic                             res_ready,
	input  srsi_pkg::res_t                   res,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [srsi_pkg::OutTdataW-1:0]   m_axis_tdata
);

	import srsi_pkg::*;

	logic                 tvalid_q;
	logic [OutTdataW-1:0] tdata_q;

	assign res_ready = !tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			tdata_q <= OutTdataW'(res);
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;

endmodule

### hdl/sorted_reference_set_intersection_top.sv
// top level of the sorted reference set intersection block
//
//   group    dir  tdata (low bit up)                                       tuser
//   s_axis   in   ref_file 8, ref_start 32, ref_length 16, read_index 10   req_type 3
//   m_axis   out  set_count 11, total_length 26, matched, overflow,        -
//                 entry_valid, entry_file 8, entry_start 32, entry_length 16
//
// load, end of list, clear, unused codes and out-of-range reads finish in the execute state
// an in-range read adds a wait state for the registered table read port
// an intersect passes through the compare state once per table entry compared,
// each merge step being one read of the table memory
// no table clearing after reset; entries beyond the set count are never read
// a result waits in the output register while the next transfer is taken in
module sorted_reference_set_intersection_top #(
	parameter int MAX_REFS     = 1024,
	parameter int FILE_ID_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// ref_file, ref_start, ref_length, read_index, zero fill
	input  logic [srsi_pkg::InTdataW-1:0]    s_axis_tdata,
	// req_type
	input  logic [srsi_pkg::ReqW-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// set_count, total_length, matched, overflow, entry_valid, entry_file,
	// entry_start, entry_length
	output logic [srsi_pkg::OutTdataW-1:0]   m_axis_tdata
);

	import srsi_pkg::*;

	localparam int AW = $clog2(MAX_REFS);
	localparam int KW = FILE_ID_BITS + 48;

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [KW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [KW-1:0] mem_rdata;

	srsi_ctrl #(
		.MAX_REFS     (MAX_REFS),
		.FILE_ID_BITS (FILE_ID_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (s_axis_tuser),
		.in_file   (s_axis_tdata[7:0]),
		.in_start  (s_axis_tdata[39:8]),
		.in_len    (s_axis_tdata[55:40]),
		.in_idx    (s_axis_tdata[65:56]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	srsi_mem #(
		.DEPTH (MAX_REFS),
		.AW    (AW),
		.DW    (KW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	srsi_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

### verif/srsi_checker.sv
// scoreboard for the sorted reference set intersection block: mirrors the set and checks results
`timescale 1ns / 100ps

module srsi_checker #(
	parameter int MAX_REFS     = 1024,
	parameter int FILE_ID_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [srsi_pkg::InTdataW-1:0]   s_tdata,
	input  logic [srsi_pkg::ReqW-1:0]       s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [srsi_pkg::OutTdataW-1:0]  m_tdata,
	output int                              errors,
	output int                              pending,
	output int                              checked,
	output int                              match_count,
	output int                              overflows
);

	typedef struct packed {
		logic [srsi_pkg::FileInW-1:0] file;
		logic [srsi_pkg::StartW-1:0]  start;
		logic [srsi_pkg::LenW-1:0]    length;
	} ref_t;

	localparam logic [srsi_pkg::FileInW-1:0] FileMask =
		srsi_pkg::FileInW'((1 << FILE_ID_BITS) - 1);

	ref_t                         refs [MAX_REFS];
	int                           set_size;
	int                           scan_pos;
	int                           keep_pos;
	logic [srsi_pkg::TotalW-1:0]  set_total;
	logic [srsi_pkg::TotalW-1:0]  keep_total;
	srsi_pkg::res_t               awaited_results [$];
	int                           fail_total = 0;
	int                           done_total = 0;
	int                           match_total = 0;
	int                           refuse_total = 0;

	function automatic srsi_pkg::res_t step_ref_set(input logic [srsi_pkg::ReqW-1:0] req,
			input ref_t r, input logic [srsi_pkg::IdxW-1:0] idx);
		srsi_pkg::res_t res;
		bit             stop;
		res = '0;
		stop = 0;
		case (req)
			srsi_pkg::REQ_LOAD: begin
				if (set_size < MAX_REFS) begin
					refs[set_size] = r;
					set_size++;
					set_total = set_total + r.length;
				end else begin
					res.overflow = 1'b1;
				end
				scan_pos = 0;
				keep_pos = 0;
				keep_total = '0;
			end
			srsi_pkg::REQ_ISECT: begin
				while (!stop && scan_pos < set_size) begin
					if (r < refs[scan_pos]) begin
						stop = 1;
					end else if (r == refs[scan_pos]) begin
						refs[keep_pos] = refs[scan_pos];
						keep_total = keep_total + refs[scan_pos].length;
						keep_pos++;
						scan_pos++;
						res.matched = 1'b1;
						stop = 1;
					end else begin
						scan_pos++;
					end
				end
			end
			srsi_pkg::REQ_END: begin
				set_size = keep_pos;
				set_total = keep_total;
				scan_pos = 0;
				keep_pos = 0;
				keep_total = '0;
			end
			srsi_pkg::REQ_READ: begin
				if (int'(idx) < set_size) begin
					res.entry_valid = 1'b1;
					res.entry_file = refs[idx].file;
					res.entry_start = refs[idx].start;
					res.entry_length = refs[idx].length;
				end
			end
			srsi_pkg::REQ_CLEAR: begin
				set_size = 0;
				set_total = '0;
				scan_pos = 0;
				keep_pos = 0;
				keep_total = '0;
			end
			default: begin
			end
		endcase
		res.set_count = srsi_pkg::CountOutW'(set_size);
		res.total_length = set_total;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		srsi_pkg::res_t got;
		srsi_pkg::res_t want;
		ref_t           r;
		if (!arst_n) begin
			awaited_results.delete();
			set_size = 0;
			scan_pos = 0;
			keep_pos = 0;
			set_total = '0;
			keep_total = '0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = srsi_pkg::res_t'(m_tdata);
				if (awaited_results.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("result transfer with nothing expected: %h", m_tdata);
				end else begin
					want = awaited_results.pop_front();
					done_total++;
					if (got.set_count !== want.set_count
							|| got.total_length !== want.total_length
							|| got.matched !== want.matched
							|| got.overflow !== want.overflow
							|| got.entry_valid !== want.entry_valid
							|| got.entry_file !== want.entry_file
							|| got.entry_start !== want.entry_start
							|| got.entry_length !== want.entry_length) begin
						fail_total++;
						if (fail_total <= 10) begin
							$display("result %0d mismatch (expected/actual):", done_total);
							$display("  count %0d/%0d total %0d/%0d matched %0b/%0b overflow %0b/%0b",
								want.set_count, got.set_count, want.total_length,
								got.total_length, want.matched, got.matched,
								want.overflow, got.overflow);
							$display("  valid %0b/%0b file %h/%h start %h/%h length %h/%h",
								want.entry_valid, got.entry_valid, want.entry_file,
								got.entry_file, want.entry_start, got.entry_start,
								want.entry_length, got.entry_length);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				r.file = s_tdata[7:0] & FileMask;
				r.start = s_tdata[39:8];
				r.length = s_tdata[55:40];
				want = step_ref_set(s_tuser, r, s_tdata[65:56]);
				if (want.matched)
					match_total++;
				if (want.overflow)
					refuse_total++;
				awaited_results.push_back(want);
			end
			pending <= awaited_results.size();
		end
		errors <= fail_total;
		checked <= done_total;
		match_count <= match_total;
		overflows <= refuse_total;
	end

endmodule

### verif/testbench.sv
// top of the testbench: stimulus for the sorted reference set intersection block and the verdict
`timescale 1ns / 100ps

module testbench;

	localparam int MaxRefs     = 1024;
	localparam int FileIdBits  = 8;
	localparam int Limit       = 500000;
	localparam int HoldCycles  = 300;
	localparam int RandomItems = 1200;
	localparam int IdlePct     = 38;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic [srsi_pkg::InTdataW-1:0]   s_tdata = '0;
	logic [srsi_pkg::ReqW-1:0]       s_tuser = '0;
	logic                            m_tready = 1'b0;
	wire                             s_tready;
	wire                             m_tvalid;
	wire  [srsi_pkg::OutTdataW-1:0]  m_tdata;

	int          errors;
	int          pending;
	int          checked;
	int          match_count;
	int          overflows;
	bit          calm = 0;
	int          hold_asked = 0;
	int          hold_taken = 0;
	int          hold_left = 0;
	int          cycles = 0;
	int          sent_by_req [8];
	int          useful_sent = 0;
	logic [55:0] list_keys [$];

	sorted_reference_set_intersection_top #(
		.MAX_REFS(MaxRefs),
		.FILE_ID_BITS(FileIdBits)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata)
	);

	srsi_checker #(
		.MAX_REFS(MaxRefs),
		.FILE_ID_BITS(FileIdBits)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.match_count(match_count),
		.overflows(overflows)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			hold_taken <= hold_asked;
			hold_left <= HoldCycles;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
		end
	end

	initial begin
		while (cycles < Limit) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
		$display("testbench: FAIL");
		$finish;
	end

	function automatic logic [55:0] rand_key();
		return 56'({$urandom, $urandom});
	endfunction

	// keys are {file, start, length}, so numeric order is tuple order
	function automatic logic [55:0] next_key(input logic [55:0] k);
		int r;
		r = $urandom_range(0, 19);
		if (r <= 2)
			return k;
		else if (r <= 9)
			return k + 56'($urandom_range(1, 4));
		else if (r <= 15)
			return k + {24'd0, 16'($urandom_range(1, 4)), 16'd0};
		else if (r <= 18)
			return k + 56'($urandom_range(1, 24'hFFFFFF));
		else
			return k + {8'd1, 48'd0};
	endfunction

	task automatic send_req(input logic [srsi_pkg::ReqW-1:0] req, input logic [55:0] key,
			input logic [srsi_pkg::IdxW-1:0] idx);
		if (!calm) begin
			while ($urandom_range(0, 99) < IdlePct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {6'd0, idx, key[15:0], key[47:16], key[55:48]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_by_req[req]++;
		if (req <= srsi_pkg::REQ_CLEAR)
			useful_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic load_list(input int n, input logic [55:0] base);
		logic [55:0] k;
		list_keys.delete();
		k = base;
		for (int i = 0; i < n; i++) begin
			list_keys.push_back(k);
			send_req(srsi_pkg::REQ_LOAD, k, 10'($urandom));
			k = next_key(k);
		end
	endtask

	task automatic stream_pass();
		int r;
		foreach (list_keys[i]) begin
			r = $urandom_range(0, 9);
			if (r <= 5) begin
				send_req(srsi_pkg::REQ_ISECT, list_keys[i], 10'($urandom));
			end else if (r == 6) begin
				send_req(srsi_pkg::REQ_ISECT, list_keys[i] - 56'd1, 10'($urandom));
			end else if (r == 8) begin
				send_req(srsi_pkg::REQ_ISECT, list_keys[i] + 56'd1, 10'($urandom));
			end else if (r == 9) begin
				send_req(srsi_pkg::REQ_ISECT, list_keys[i], 10'($urandom));
				send_req(srsi_pkg::REQ_ISECT, list_keys[i], 10'($urandom));
			end
			if ($urandom_range(0, 19) == 0)
				send_req(srsi_pkg::REQ_READ, rand_key(),
					10'($urandom_range(0, list_keys.size())));
		end
	endtask

	initial begin
		int          random_start;
		int          n;
		logic [55:0] base;
		foreach (sent_by_req[i])
			sent_by_req[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, unused codes, edge tuples, merge cases, pass abandoned by a load
		send_req(srsi_pkg::REQ_READ, rand_key(), 10'd0);
		send_req(srsi_pkg::REQ_END, rand_key(), 10'd0);
		for (int c = srsi_pkg::REQ_CLEAR + 1; c < 8; c++)
			send_req(srsi_pkg::ReqW'(c), rand_key(), 10'($urandom));
		send_req(srsi_pkg::REQ_LOAD, 56'd0, 10'd0);
		send_req(srsi_pkg::REQ_LOAD, {8'h00, 32'h0, 16'hFFFF}, 10'h3FF);
		send_req(srsi_pkg::REQ_LOAD, {8'h7F, 32'hFFFF_FFFF, 16'h0}, 10'd0);
		send_req(srsi_pkg::REQ_LOAD, {8'hFF, 32'hFFFF_FFFF, 16'hFFFE}, 10'd0);
		send_req(srsi_pkg::REQ_LOAD, {56{1'b1}}, 10'd0);
		send_req(srsi_pkg::REQ_READ, 56'd0, 10'd0);
		send_req(srsi_pkg::REQ_READ, {56{1'b1}}, 10'd4);
		send_req(srsi_pkg::REQ_READ, 56'd0, 10'd5);
		send_req(srsi_pkg::REQ_READ, 56'd0, 10'h3FF);
		send_req(srsi_pkg::REQ_ISECT, 56'd0, 10'd0);
		send_req(srsi_pkg::REQ_ISECT, {8'h00, 32'h0, 16'h0001}, 10'd0);
		send_req(srsi_pkg::REQ_ISECT, {8'h7F, 32'hFFFF_FFFF, 16'h0}, 10'd0);
		send_req(srsi_pkg::REQ_READ, 56'd0, 10'd1);
		send_req(srsi_pkg::REQ_ISECT, {56{1'b1}}, 10'd0);
		send_req(srsi_pkg::REQ_ISECT, {56{1'b1}}, 10'd0);
		send_req(srsi_pkg::REQ_END, 56'd0, 10'd0);
		send_req(srsi_pkg::REQ_READ, 56'd0, 10'd2);
		send_req(srsi_pkg::REQ_READ, 56'd0, 10'd3);
		send_req(srsi_pkg::REQ_ISECT, 56'd0, 10'd0);
		send_req(srsi_pkg::REQ_LOAD, 56'd5, 10'd0);
		send_req(srsi_pkg::REQ_END, 56'd0, 10'd0);
		send_req(srsi_pkg::REQ_CLEAR, 56'd0, 10'd0);

		// full table with no idling: receiver holds off while loads keep coming
		calm <= 1;
		hold_asked <= hold_asked + 1;
		send_req(srsi_pkg::REQ_CLEAR, rand_key(), 10'd0);
		load_list(MaxRefs, {1'b0, 55'(rand_key())});
		send_req(srsi_pkg::REQ_LOAD, rand_key(), 10'($urandom));
		send_req(srsi_pkg::REQ_LOAD, rand_key(), 10'($urandom));
		stream_pass();
		send_req(srsi_pkg::REQ_END, rand_key(), 10'd0);
		repeat (20)
			send_req(srsi_pkg::REQ_READ, rand_key(), 10'($urandom));
		drain();
		calm <= 0;

		// random lists and passes, mixed with noise
		random_start = useful_sent;
		while (useful_sent - random_start < RandomItems) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 1))
					send_req(srsi_pkg::REQ_CLEAR, rand_key(), 10'($urandom));
				n = $urandom_range(1, 24);
				case ($urandom_range(0, 3))
					0: base = 56'd0;
					1: base = {8'hFF, 48'(rand_key())};
					default: base = rand_key();
				endcase
				load_list(n, base);
				repeat ($urandom_range(0, 2))
					send_req(srsi_pkg::REQ_READ, rand_key(), 10'($urandom_range(0, n + 1)));
				repeat ($urandom_range(1, 3)) begin
					stream_pass();
					send_req(srsi_pkg::REQ_END, rand_key(), 10'($urandom));
				end
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 3) == 0)
						send_req(srsi_pkg::REQ_READ, rand_key(), 10'($urandom));
					else
						send_req(srsi_pkg::REQ_READ, rand_key(),
							10'($urandom_range(0, n + 1)));
				end
			end else begin
				repeat ($urandom_range(1, 8))
					send_req(srsi_pkg::ReqW'($urandom_range(0, 7)), rand_key(),
						10'($urandom));
			end
		end

		drain();
		repeat (40) @(posedge clk);
		$display("covered %0d loads (%0d refused on a full table), %0d intersect steps (%0d matched)",
			sent_by_req[srsi_pkg::REQ_LOAD], overflows, sent_by_req[srsi_pkg::REQ_ISECT],
			match_count);
		$display("plus %0d list ends, %0d reads, %0d clears, %0d unused codes; %0d results checked",
			sent_by_req[srsi_pkg::REQ_END], sent_by_req[srsi_pkg::REQ_READ],
			sent_by_req[srsi_pkg::REQ_CLEAR], sent_by_req[5] + sent_by_req[6] + sent_by_req[7],
			checked);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
